/* design/sssd_pkg.sv */
// ----------------------------------------------------------------------------
// sssd_pkg: seven-segment scan display shared definitions
// Action, button and mode codes, digit codes, divider reciprocals and the
// segment pattern lookup.
// ----------------------------------------------------------------------------
package sssd_pkg;

  // transaction kinds on the input channel
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_BUTTON = 2'd1;
  localparam logic [1:0] ACT_SWITCH = 2'd2;

  // one-hot button lines
  localparam logic [4:0] BTN_MODE0 = 5'h01;
  localparam logic [4:0] BTN_MODE1 = 5'h02;
  localparam logic [4:0] BTN_MODE2 = 5'h04;
  localparam logic [4:0] BTN_MODE3 = 5'h08;
  localparam logic [4:0] BTN_MODE4 = 5'h10;

  // display modes
  localparam logic [2:0] MODE_BIN   = 3'd0;
  localparam logic [2:0] MODE_HEX   = 3'd1;
  localparam logic [2:0] MODE_DEC   = 3'd2;
  localparam logic [2:0] MODE_HOLD3 = 3'd3;
  localparam logic [2:0] MODE_HOLD4 = 3'd4;

  localparam int          CODE_W     = 5;
  localparam logic [4:0]  BLANK_CODE = 5'd16;
  localparam logic [7:0]  SEG_BLANK  = 8'hFF;

  // floor(v / d) = (v * M) >> S, exact for every 16-bit v
  localparam int PROD_W   = 33;
  localparam int RECIP_10    = 52429;
  localparam int RECIP_100   = 83887;
  localparam int RECIP_1000  = 67109;
  localparam int RECIP_10000 = 107375;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [PROD_W-1:0] prod_t;

  // active-low {dp,g,f,e,d,c,b,a}
  function automatic logic [7:0] seg_pattern(input code_t code);
    logic [7:0] pat;
    case (code)
      5'd0:    pat = 8'hC0;
      5'd1:    pat = 8'hF9;
      5'd2:    pat = 8'hA4;
      5'd3:    pat = 8'hB0;
      5'd4:    pat = 8'h99;
      5'd5:    pat = 8'h92;
      5'd6:    pat = 8'h82;
      5'd7:    pat = 8'hF8;
      5'd8:    pat = 8'h80;
      5'd9:    pat = 8'h90;
      5'd10:   pat = 8'h88;
      5'd11:   pat = 8'h83;
      5'd12:   pat = 8'hC6;
      5'd13:   pat = 8'hA1;
      5'd14:   pat = 8'h86;
      5'd15:   pat = 8'h8E;
      default: pat = SEG_BLANK;
    endcase
    return pat;
  endfunction

  // lo - 10*hi, known to land in 0..9, so four bits of arithmetic suffice
  function automatic logic [3:0] dec_digit(input logic [3:0] lo, input logic [3:0] hi);
    logic [3:0] ten_hi;
    ten_hi = (hi << 3) + (hi << 1);
    return lo - ten_hi;
  endfunction

endpackage

/* design/seven_segment_scan_display_top.sv */
// ----------------------------------------------------------------------------
// seven_segment_scan_display_top: multiplexed seven-segment scan driver
// Holds the digit codes, scans them out one per tick and refills them from
// the switches in binary, hex or decimal form by mode (hold modes keep them).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per action:
//   scan tick, button press or switch change. Only a scan tick produces a
//   result on the output channel (out_valid / out_stall): the segment
//   pattern of the digit under the scan index and its active-low select.
//   Button and switch transactions only update mode or digit state.
//   Path: a tick's result goes from the input register into the result
//   register, where it can be taken; a full, stalled output register
//   holds the tick in the input register meanwhile.
//   Throughput: one transaction per cycle unless a tick waits on a stalled
//   output. The decimal split uses four parallel reciprocal multipliers
//   ahead of the input register, so conversion is combinational.
//   Stall: when the output register is full and stalled, a tick in the
//   input register waits and in_stall rises; button and switch
//   transactions still drain since they produce no result.
//   Reset (rst_n low, synchronous): digits load 1..NUM_DIGITS, scan index
//   and mode go to zero, both channels empty.
// ----------------------------------------------------------------------------
module seven_segment_scan_display_top
  import sssd_pkg::*;
#(
  parameter int NUM_DIGITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [4:0]  in_button_code,
  input  logic [15:0] in_switch_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_segment_pattern,
  output logic [7:0]  out_digit_select
);

  localparam int IDX_W = $clog2(NUM_DIGITS);

  // quotients of the switch value, computed ahead of the input register
  prod_t prod1, prod2, prod3, prod4;
  logic [12:0] q1_in;
  logic [9:0]  q2_in;
  logic [6:0]  q3_in;
  logic [2:0]  q4_in;

  // input register
  logic        s1_valid_r, s1_valid_nxt;
  logic [1:0]  s1_action_r;
  logic [4:0]  s1_button_r;
  logic [15:0] s1_switch_r;
  logic [12:0] q1_r;
  logic [9:0]  q2_r;
  logic [6:0]  q3_r;
  logic [2:0]  q4_r;

  // block state
  code_t            digit_r [NUM_DIGITS];
  code_t            digit_nxt [NUM_DIGITS];
  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [2:0]       mode_r, mode_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_seg_r;
  logic [7:0] out_sel_r;

  logic in_fire, out_free, s1_is_tick, s1_go, res_load;

  code_t            bin_dig [8];
  code_t            hex_dig [4];
  code_t            dec_dig [5];
  code_t            cur_code;
  logic [IDX_W-1:0] sel_pos;
  logic [7:0]       sel;

  assign prod1 = {17'd0, in_switch_value} * PROD_W'(RECIP_10);
  assign prod2 = {17'd0, in_switch_value} * PROD_W'(RECIP_100);
  assign prod3 = {17'd0, in_switch_value} * PROD_W'(RECIP_1000);
  assign prod4 = {17'd0, in_switch_value} * PROD_W'(RECIP_10000);
  assign q1_in = prod1[31:19];
  assign q2_in = prod2[32:23];
  assign q3_in = prod3[32:26];
  assign q4_in = prod4[32:30];

  // handshake
  assign out_free   = !out_valid_r || !out_stall;
  assign s1_is_tick = (s1_action_r == ACT_TICK);
  assign s1_go      = s1_valid_r && (!s1_is_tick || out_free);
  assign res_load   = s1_go && s1_is_tick;
  assign in_stall   = s1_valid_r && !s1_go;
  assign in_fire    = in_valid && !in_stall;

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_comb begin
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // refill candidates
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      bin_dig[j] = {4'd0, s1_switch_r[7-j]};
    end
    for (int j = 0; j < 4; j++) begin
      hex_dig[j] = {1'b0, s1_switch_r[(12-4*j) +: 4]};
    end
    dec_dig[0] = {2'd0, q4_r};
    dec_dig[1] = {1'b0, dec_digit(q3_r[3:0], {1'b0, q4_r})};
    dec_dig[2] = {1'b0, dec_digit(q2_r[3:0], q3_r[3:0])};
    dec_dig[3] = {1'b0, dec_digit(q1_r[3:0], q2_r[3:0])};
    dec_dig[4] = {1'b0, dec_digit(s1_switch_r[3:0], q1_r[3:0])};
  end

  // state update
  always_comb begin
    scan_idx_nxt = scan_idx_r;
    mode_nxt     = mode_r;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      digit_nxt[k] = digit_r[k];
    end
    if (s1_go) begin
      case (s1_action_r)
        ACT_TICK: begin
          if (scan_idx_r == IDX_W'(NUM_DIGITS - 1)) begin
            scan_idx_nxt = '0;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end
        ACT_BUTTON: begin
          case (s1_button_r)
            BTN_MODE0: mode_nxt = MODE_BIN;
            BTN_MODE1: mode_nxt = MODE_HEX;
            BTN_MODE2: mode_nxt = MODE_DEC;
            BTN_MODE3: mode_nxt = MODE_HOLD3;
            BTN_MODE4: mode_nxt = MODE_HOLD4;
            default:   mode_nxt = mode_r;
          endcase
        end
        ACT_SWITCH: begin
          case (mode_r)
            MODE_BIN: begin
              for (int k = 0; k < NUM_DIGITS; k++) begin
                digit_nxt[k] = (k < 8) ? bin_dig[3'(k)] : BLANK_CODE;
              end
            end
            MODE_HEX: begin
              for (int k = 0; k < NUM_DIGITS; k++) begin
                digit_nxt[k] = (k < 4) ? hex_dig[2'(k)] : BLANK_CODE;
              end
            end
            MODE_DEC: begin
              for (int k = 0; k < NUM_DIGITS; k++) begin
                digit_nxt[k] = (k < 5) ? dec_dig[3'(k)] : BLANK_CODE;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // scan output
  assign cur_code = digit_r[scan_idx_r];
  assign sel_pos  = IDX_W'(NUM_DIGITS - 1) - scan_idx_r;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      sel[b] = !(sel_pos == IDX_W'(b));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      scan_idx_r  <= '0;
      mode_r      <= MODE_BIN;
      for (int k = 0; k < NUM_DIGITS; k++) begin
        digit_r[k] <= CODE_W'(k + 1);
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      scan_idx_r  <= scan_idx_nxt;
      mode_r      <= mode_nxt;
      for (int k = 0; k < NUM_DIGITS; k++) begin
        digit_r[k] <= digit_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r <= in_action;
      s1_button_r <= in_button_code;
      s1_switch_r <= in_switch_value;
      q1_r        <= q1_in;
      q2_r        <= q2_in;
      q3_r        <= q3_in;
      q4_r        <= q4_in;
    end
    if (res_load) begin
      out_seg_r <= seg_pattern(cur_code);
      out_sel_r <= sel;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_segment_pattern = out_seg_r;
  assign out_digit_select    = out_sel_r;

  // a fresh result only comes from a tick leaving the input register
  a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_action_r == ACT_TICK))
    else $error("result appeared without a tick transaction");

  // at most one digit enabled
  a_select_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($countones(out_sel_r) >= 7))
    else $error("more than one digit selected");

  // scan index moves only on a completed tick
  a_scan_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(res_load) |-> $stable(scan_idx_r))
    else $error("scan index moved without a tick");

endmodule
